>>> sv/yrgb_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// yrgb_pkg
// Shared widths, Q.16 color coefficients and the channel clamp for the
// YUYV to RGB pair converter.
// ----------------------------------------------------------------------------
package yrgb_pkg;

  localparam int BYTE_W = 8;
  localparam int ACC_W  = 27;
  localparam int FRAC_W = 16;

  // Coefficients carry the factor 255 and 16 fractional bits.
  localparam logic signed [ACC_W-1:0] COEF_Y   = 27'sd76289;
  localparam logic signed [ACC_W-1:0] COEF_B_U = 27'sd17;
  localparam logic signed [ACC_W-1:0] COEF_B_V = 27'sd104448;
  localparam logic signed [ACC_W-1:0] OFFS_B   = -27'sd14572585;
  localparam logic signed [ACC_W-1:0] COEF_G_U = -27'sd25769;
  localparam logic signed [ACC_W-1:0] COEF_G_V = -27'sd53193;
  localparam logic signed [ACC_W-1:0] OFFS_G   = 27'sd8873902;
  localparam logic signed [ACC_W-1:0] COEF_R_U = 27'sd132607;
  localparam logic signed [ACC_W-1:0] OFFS_R   = -27'sd18182308;

  typedef struct packed {
    logic signed [ACC_W-1:0] red;
    logic signed [ACC_W-1:0] green;
    logic signed [ACC_W-1:0] blue;
  } chroma_sum_t;

  typedef struct packed {
    logic [BYTE_W-1:0] red;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] blue;
  } rgb_t;

  // Negative sums give 0, sums of 256.0 or more give 255, otherwise the
  // integer part is kept.
  function automatic logic [BYTE_W-1:0] clamp_channel(input logic signed [ACC_W-1:0] acc);
    logic [BYTE_W-1:0] res;
    if (acc[ACC_W-1]) begin
      res = '0;
    end else if (|acc[ACC_W-2:FRAC_W+BYTE_W]) begin
      res = '1;
    end else begin
      res = acc[FRAC_W+BYTE_W-1:FRAC_W];
    end
    return res;
  endfunction

endpackage
`default_nettype wire

>>> sv/yrgb_pixel.sv
`default_nettype none
// ----------------------------------------------------------------------------
// yrgb_pixel
// Luma path of one pixel: scales the luma byte, adds the shared chroma sums
// and clamps each channel. Four register stages, all advanced by en.
// ----------------------------------------------------------------------------
module yrgb_pixel (
  input  wire logic                        clk,
  input  wire logic                        en,
  input  wire logic [yrgb_pkg::BYTE_W-1:0] luma,
  input  wire yrgb_pkg::chroma_sum_t       chroma,
  output yrgb_pkg::rgb_t                   rgb
);

  logic signed [yrgb_pkg::ACC_W-1:0] luma_prod_r, luma_prod_nxt;
  logic signed [yrgb_pkg::ACC_W-1:0] luma_dly_r;
  yrgb_pkg::chroma_sum_t             acc_r, acc_nxt;
  yrgb_pkg::rgb_t                    rgb_r, rgb_nxt;

  always_comb begin
    luma_prod_nxt = $signed({{(yrgb_pkg::ACC_W-yrgb_pkg::BYTE_W){1'b0}}, luma})
                    * yrgb_pkg::COEF_Y;
    acc_nxt.red   = luma_dly_r + chroma.red;
    acc_nxt.green = luma_dly_r + chroma.green;
    acc_nxt.blue  = luma_dly_r + chroma.blue;
    rgb_nxt.red   = yrgb_pkg::clamp_channel(acc_r.red);
    rgb_nxt.green = yrgb_pkg::clamp_channel(acc_r.green);
    rgb_nxt.blue  = yrgb_pkg::clamp_channel(acc_r.blue);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      luma_prod_r <= luma_prod_nxt;
      luma_dly_r  <= luma_prod_r;
      acc_r       <= acc_nxt;
      rgb_r       <= rgb_nxt;
    end
  end

  assign rgb = rgb_r;

endmodule
`default_nettype wire

>>> sv/yuyv_to_rgb_pair_converter.sv
`default_nettype none
// ----------------------------------------------------------------------------
// yuyv_to_rgb_pair_converter
// Converts one YUYV group into two RGB888 pixels sharing the chroma.
// ----------------------------------------------------------------------------
// Usage:
// A request on the in_ channel carries Y0, U, Y1, V and an end-of-frame flag.
// Each request yields exactly one request on the out_ channel with two
// clamped RGB pixels and a copy of the flag.
// Throughput is one group per cycle unless the receiver stalls; the stage
// depth is set by the constant multipliers of the first stage and the
// three-operand chroma adders of the second.
// Stages: multiply, chroma sum, luma add, clamp into the output register.
// When the receiver stalls while a result waits, the whole pipeline holds
// and in_stall is raised in the same cycle, so nothing is lost or repeated.
// Reset clears all stage valid bits; data registers are not reset.
// ----------------------------------------------------------------------------
module yuyv_to_rgb_pair_converter (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output      logic                        in_stall,
  input  wire logic [yrgb_pkg::BYTE_W-1:0] in_luma_first,
  input  wire logic [yrgb_pkg::BYTE_W-1:0] in_chroma_u,
  input  wire logic [yrgb_pkg::BYTE_W-1:0] in_luma_second,
  input  wire logic [yrgb_pkg::BYTE_W-1:0] in_chroma_v,
  input  wire logic                        in_frame_end,
  output      logic                        out_valid,
  input  wire logic                        out_stall,
  output      logic [yrgb_pkg::BYTE_W-1:0] out_red_first,
  output      logic [yrgb_pkg::BYTE_W-1:0] out_green_first,
  output      logic [yrgb_pkg::BYTE_W-1:0] out_blue_first,
  output      logic [yrgb_pkg::BYTE_W-1:0] out_red_second,
  output      logic [yrgb_pkg::BYTE_W-1:0] out_green_second,
  output      logic [yrgb_pkg::BYTE_W-1:0] out_blue_second,
  output      logic                        out_frame_last
);

  localparam int STAGES = 4;

  logic                              advance;
  logic [STAGES-1:0]                 valid_r, valid_nxt;
  logic [STAGES-1:0]                 frame_r, frame_nxt;
  logic signed [yrgb_pkg::ACC_W-1:0] r_u_r, g_u_r, g_v_r, b_u_r, b_v_r;
  logic signed [yrgb_pkg::ACC_W-1:0] u_ext, v_ext;
  yrgb_pkg::chroma_sum_t             chroma_r, chroma_nxt;
  yrgb_pkg::rgb_t                    rgb_first, rgb_second;

  // The pipeline moves unless a finished result is held by the receiver.
  assign advance  = !(valid_r[STAGES-1] && out_stall);
  assign in_stall = !advance;

  assign valid_nxt = {valid_r[STAGES-2:0], in_valid};
  assign frame_nxt = {frame_r[STAGES-2:0], in_frame_end};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= '0;
    end else if (advance) begin
      valid_r <= valid_nxt;
    end
  end

  assign u_ext = $signed({{(yrgb_pkg::ACC_W-yrgb_pkg::BYTE_W){1'b0}}, in_chroma_u});
  assign v_ext = $signed({{(yrgb_pkg::ACC_W-yrgb_pkg::BYTE_W){1'b0}}, in_chroma_v});

  always_comb begin
    chroma_nxt.red   = r_u_r + yrgb_pkg::OFFS_R;
    chroma_nxt.green = g_u_r + g_v_r + yrgb_pkg::OFFS_G;
    chroma_nxt.blue  = b_u_r + b_v_r + yrgb_pkg::OFFS_B;
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      frame_r  <= frame_nxt;
      r_u_r    <= u_ext * yrgb_pkg::COEF_R_U;
      g_u_r    <= u_ext * yrgb_pkg::COEF_G_U;
      g_v_r    <= v_ext * yrgb_pkg::COEF_G_V;
      b_u_r    <= u_ext * yrgb_pkg::COEF_B_U;
      b_v_r    <= v_ext * yrgb_pkg::COEF_B_V;
      chroma_r <= chroma_nxt;
    end
  end

  yrgb_pixel u_pixel_first (
    .clk    (clk),
    .en     (advance),
    .luma   (in_luma_first),
    .chroma (chroma_r),
    .rgb    (rgb_first)
  );

  yrgb_pixel u_pixel_second (
    .clk    (clk),
    .en     (advance),
    .luma   (in_luma_second),
    .chroma (chroma_r),
    .rgb    (rgb_second)
  );

  assign out_valid        = valid_r[STAGES-1];
  assign out_frame_last   = frame_r[STAGES-1];
  assign out_red_first    = rgb_first.red;
  assign out_green_first  = rgb_first.green;
  assign out_blue_first   = rgb_first.blue;
  assign out_red_second   = rgb_second.red;
  assign out_green_second = rgb_second.green;
  assign out_blue_second  = rgb_second.blue;

endmodule
`default_nettype wire
